/* hdl/assert_macros.svh */
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset
`define PDR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pdr assertion failed");

// Check on every clock edge, reset included
`define PDR_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("pdr reset assertion failed");

`endif

/* hdl/pdr_pkg.sv */
package pdr_pkg;

  typedef logic [6:0]  pct_t;
  typedef logic [15:0] cmp_t;
  typedef logic [16:0] full_t;
  typedef logic [22:0] prod_t;
  typedef logic [1:0]  func_t;
  typedef logic [1:0]  chan_t;
  typedef logic [1:0]  cfg_idx_t;

  // Function codes
  localparam func_t FUNC_UP   = 2'd0;
  localparam func_t FUNC_DOWN = 2'd1;
  localparam func_t FUNC_TICK = 2'd2;

  // Channel codes
  localparam chan_t CH_PUMP = 2'd0;
  localparam chan_t CH_PULL = 2'd1;
  localparam chan_t CH_PUSH = 2'd2;

  // Register indexes
  localparam cfg_idx_t CFG_PERIOD   = 2'd0;
  localparam cfg_idx_t CFG_FAN_MODE = 2'd1;
  localparam cfg_idx_t CFG_PULL_PCT = 2'd2;
  localparam cfg_idx_t CFG_PUSH_PCT = 2'd3;

  localparam int CfgDataW = 16;

  // Reset values and fixed percents
  localparam cmp_t PERIOD_RST   = 16'd999;
  localparam cmp_t CMP_RST      = 16'd1000;
  localparam pct_t PULL_PCT_RST = 7'd60;
  localparam pct_t PUSH_PCT_RST = 7'd30;
  localparam pct_t PCT_FULL     = 7'd100;
  localparam pct_t AUTO_PULL    = 7'd60;
  localparam pct_t AUTO_PUSH    = 7'd30;

  // Divide by 100 as multiply by ceil(2^30 / 100), exact for products below 2^23
  localparam int            RecipShift = 30;
  localparam logic [23:0]   RECIP_100  = 24'd10737419;

  // Kind of compare target
  typedef enum logic [1:0] {
    TGT_ZERO,
    TGT_FULL,
    TGT_SCALED
  } tgt_kind_e;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] channel;
    logic [6:0] percent;
  } in_req_t;

  typedef struct packed {
    logic        reached;
    logic [15:0] pump_cmp;
    logic [15:0] pull_cmp;
    logic [15:0] push_cmp;
    logic        soft_done;
    logic [6:0]  pull_pct_applied;
    logic [6:0]  push_pct_applied;
  } out_rsp_t;

  // Target preparation carried from the scale stage to the step stage
  typedef struct packed {
    tgt_kind_e kind;
    prod_t     prod;
  } tgt_prep_t;

endpackage

/* hdl/pdr_scale.sv */
module pdr_scale (
  input  pdr_pkg::pct_t      pct_i,
  input  pdr_pkg::full_t     full_i,
  output pdr_pkg::tgt_prep_t prep_o
);
  import pdr_pkg::*;

  pct_t        power;
  logic [23:0] prod_wide;

  // Invert the percent and scale the full count (period plus one) by the resulting power
  always_comb begin
    power     = PCT_FULL - pct_i;
    prod_wide = {7'd0, full_i} * {17'd0, power};
    prep_o.prod = prod_wide[$bits(prod_t)-1:0];
    if (pct_i >= PCT_FULL) begin
      prep_o.kind = TGT_ZERO;
    end else if (pct_i == '0) begin
      prep_o.kind = TGT_FULL;
    end else begin
      prep_o.kind = TGT_SCALED;
    end
  end

endmodule

/* hdl/pdr_step.sv */
module pdr_step (
  input  logic               up_i,
  input  pdr_pkg::tgt_prep_t prep_i,
  input  pdr_pkg::cmp_t      full_tgt_i,
  input  pdr_pkg::cmp_t      cmp_i,
  output pdr_pkg::cmp_t      cmp_o,
  output logic               reached_o
);
  import pdr_pkg::*;

  logic [46:0] mul;
  cmp_t        quot;
  cmp_t        tgt;

  // Finish the divide by 100 and form the compare target
  always_comb begin
    mul  = {24'd0, prep_i.prod} * {23'd0, RECIP_100};
    quot = mul[RecipShift +: 16];
    case (prep_i.kind)
      TGT_ZERO:   tgt = '0;
      TGT_FULL:   tgt = full_tgt_i;
      TGT_SCALED: tgt = (quot == '0) ? '0 : quot - 16'd1;
      default:    tgt = '0;
    endcase
  end

  // Move one count toward the target, or flag it reached
  always_comb begin
    cmp_o     = cmp_i;
    reached_o = 1'b1;
    if (up_i) begin
      if (cmp_i < tgt) begin
        cmp_o     = cmp_i + 16'd1;
        reached_o = 1'b0;
      end
    end else begin
      if (cmp_i > tgt) begin
        cmp_o     = cmp_i - 16'd1;
        reached_o = 1'b0;
      end
    end
  end

endmodule

/* hdl/pwm_duty_ramp_soft_start_top.sv */
// Channel   Handshake              Payload
// request   in_valid_i/in_stall_o  in_req_i (func, channel, percent)
// result    out_valid_o/out_stall_i out_rsp_o (reached, compares, soft start)
// config    cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One request per cycle while no held result stalls the pipeline; each result passes the stages below.
// Stages: input register, scale multiply register, divide-and-step into the result register.
// The scale multiply and the reciprocal multiply set the stage split.
// Reset restores the registers to their defaults and the compares to 1000.
// A stalled result holds the whole pipeline, so in_stall_o rises when out_stall_i meets a valid result.
module pwm_duty_ramp_soft_start_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  pdr_pkg::in_req_t         in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output pdr_pkg::out_rsp_t        out_rsp_o,
  input  logic                     cfg_we_i,
  input  pdr_pkg::cfg_idx_t        cfg_idx_i,
  input  logic [pdr_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import pdr_pkg::*;

  // Configuration registers
  cmp_t period_q;
  logic fan_mode_q;
  pct_t pull_pct_q;
  pct_t push_pct_q;

  // Pipeline
  logic      adv;
  logic      s1_valid_q;
  in_req_t   s1_req_q;
  logic      s2_valid_q;
  func_t     s2_func_q;
  chan_t     s2_chan_q;
  tgt_prep_t s2_prep_a_q, s2_prep_b_q;
  tgt_prep_t prep_a, prep_b;
  logic      out_valid_q;
  out_rsp_t  out_rsp_q, out_rsp_d;

  // Block state
  cmp_t pump_q, pump_d, pull_q, pull_d, push_q, push_d;
  logic active_q, active_d, finished_q, finished_d;
  pct_t last_pull_q, last_pull_d, last_push_q, last_push_d;

  full_t full;
  cmp_t  full_tgt;
  pct_t  fan_pull_pct, fan_push_pct, pct_a;
  cmp_t  cmp_a_in, cmp_a_out, cmp_b_out;
  logic  up_a, reached_a, reached_b, reached;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_RST;
      fan_mode_q <= 1'b1;
      pull_pct_q <= PULL_PCT_RST;
      push_pct_q <= PUSH_PCT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PERIOD:   period_q   <= cfg_wdata_i[15:0];
        CFG_FAN_MODE: fan_mode_q <= cfg_wdata_i[0];
        CFG_PULL_PCT: pull_pct_q <= cfg_wdata_i[6:0];
        CFG_PUSH_PCT: push_pct_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Full scale and fan targets for the current mode
  assign full         = {1'b0, period_q} + 17'd1;
  assign full_tgt     = full[16] ? 16'hFFFF : full[15:0];
  assign fan_pull_pct = fan_mode_q ? AUTO_PULL : pull_pct_q;
  assign fan_push_pct = fan_mode_q ? AUTO_PUSH : push_pct_q;

  // Advance the whole pipeline unless a finished result is held
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Scale stage: request percent, or the pull fan percent on a tick
  assign pct_a = (s1_req_q.func == FUNC_TICK) ? fan_pull_pct : s1_req_q.percent;

  pdr_scale u_scale_a (
    .pct_i  (pct_a),
    .full_i (full),
    .prep_o (prep_a)
  );

  pdr_scale u_scale_b (
    .pct_i  (fan_push_pct),
    .full_i (full),
    .prep_o (prep_b)
  );

  // Step stage: pick the compare that unit A works on
  always_comb begin
    up_a = (s2_func_q == FUNC_UP);
    if (s2_func_q == FUNC_TICK) begin
      cmp_a_in = pull_q;
    end else begin
      case (s2_chan_q)
        CH_PUMP: cmp_a_in = pump_q;
        CH_PULL: cmp_a_in = pull_q;
        CH_PUSH: cmp_a_in = push_q;
        default: cmp_a_in = pump_q;
      endcase
    end
  end

  pdr_step u_step_a (
    .up_i       (up_a),
    .prep_i     (s2_prep_a_q),
    .full_tgt_i (full_tgt),
    .cmp_i      (cmp_a_in),
    .cmp_o      (cmp_a_out),
    .reached_o  (reached_a)
  );

  pdr_step u_step_b (
    .up_i       (1'b0),
    .prep_i     (s2_prep_b_q),
    .full_tgt_i (full_tgt),
    .cmp_i      (push_q),
    .cmp_o      (cmp_b_out),
    .reached_o  (reached_b)
  );

  // Work out the state after this request
  always_comb begin
    pump_d      = pump_q;
    pull_d      = pull_q;
    push_d      = push_q;
    active_d    = active_q;
    finished_d  = finished_q;
    last_pull_d = last_pull_q;
    last_push_d = last_push_q;
    reached     = 1'b0;
    case (s2_func_q)
      FUNC_UP, FUNC_DOWN: begin
        case (s2_chan_q)
          CH_PUMP: begin
            pump_d  = cmp_a_out;
            reached = reached_a;
          end
          CH_PULL: begin
            pull_d  = cmp_a_out;
            reached = reached_a;
          end
          CH_PUSH: begin
            push_d  = cmp_a_out;
            reached = reached_a;
          end
          default: ;
        endcase
      end
      FUNC_TICK: begin
        if (active_q) begin
          pull_d      = cmp_a_out;
          push_d      = cmp_b_out;
          last_pull_d = fan_pull_pct;
          last_push_d = fan_push_pct;
          reached     = reached_a & reached_b;
          if (reached_a & reached_b) begin
            active_d   = 1'b0;
            finished_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
    out_rsp_d.reached          = reached;
    out_rsp_d.pump_cmp         = pump_d;
    out_rsp_d.pull_cmp         = pull_d;
    out_rsp_d.push_cmp         = push_d;
    out_rsp_d.soft_done        = finished_d;
    out_rsp_d.pull_pct_applied = last_pull_d;
    out_rsp_d.push_pct_applied = last_push_d;
  end

  // Hold control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pump_q      <= CMP_RST;
      pull_q      <= CMP_RST;
      push_q      <= CMP_RST;
      active_q    <= 1'b1;
      finished_q  <= 1'b0;
      last_pull_q <= '0;
      last_push_q <= '0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        pump_q      <= pump_d;
        pull_q      <= pull_d;
        push_q      <= push_d;
        active_q    <= active_d;
        finished_q  <= finished_d;
        last_pull_q <= last_pull_d;
        last_push_q <= last_push_d;
      end
    end
  end

  // Advance payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_req_q    <= in_req_i;
      s2_func_q   <= s1_req_q.func;
      s2_chan_q   <= s1_req_q.channel;
      s2_prep_a_q <= prep_a;
      s2_prep_b_q <= prep_b;
      out_rsp_q   <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

/* hdl/pdr_checker.sv */
`include "assert_macros.svh"

module pdr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input pdr_pkg::out_rsp_t            out_rsp_o
);
  import pdr_pkg::*;

  // No result shows while reset is held
  `PDR_ASSERT_RST(a_no_result_in_reset, !rst_ni |=> !out_valid_o)

  // A held result keeps its payload
  `PDR_ASSERT(a_result_holds, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))

  // Soft start, once done, stays done
  `PDR_ASSERT(a_soft_done_sticks, out_valid_o && out_rsp_o.soft_done |=> !out_valid_o || out_rsp_o.soft_done)

  // A request that meets no stall comes out as a valid result
  `PDR_ASSERT(a_latency, (in_valid_i && !in_stall_o) ##1 !in_stall_o ##1 !in_stall_o |=> out_valid_o)

endmodule

bind pwm_duty_ramp_soft_start_top pdr_checker u_pdr_checker (.*);

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pdr_pkg::*;

  // Codes the block must ignore
  localparam func_t FUNC_NONE = 2'd3;
  localparam chan_t CH_NONE   = 2'd3;

  localparam int NumPhases   = 10;
  localparam int PhaseItems  = 163;
  localparam int CalmPhase   = 2;
  localparam int FinishPhase = 7;
  localparam int SettleWait  = 4;
  localparam int CycleLimit  = 200000;

  // One line of the directed plan: a register write or a request
  typedef struct packed {
    bit        is_reg;
    cfg_idx_t  idx;
    cmp_t      wdata;
    in_req_t   req;
    bit        typed;
    out_rsp_t  rsp;
  } plan_row_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_rsp;
  logic     cfg_we    = 1'b0;
  cfg_idx_t cfg_idx   = CFG_PERIOD;
  cmp_t     cfg_wdata = '0;

  bit calm = 1'b0;
  int err_cnt = 0;
  int cycle_cnt = 0;

  // Register copies and ramp state of the predictor
  cmp_t period_cfg   = PERIOD_RST;
  bit   auto_mode    = 1'b1;
  pct_t pull_pct_cfg = PULL_PCT_RST;
  pct_t push_pct_cfg = PUSH_PCT_RST;
  cmp_t ramp_cmp [0:2] = '{CMP_RST, CMP_RST, CMP_RST};
  bit   ss_running = 1'b1;
  bit   ss_done    = 1'b0;
  pct_t pull_pct_used = '0;
  pct_t push_pct_used = '0;

  out_rsp_t  due_rsp_q [$];
  plan_row_t plan [$];

  pwm_duty_ramp_soft_start_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Compare target for a percent under the current period
  function automatic cmp_t compare_target(pct_t pct);
    int unsigned full_cnt;
    int unsigned power;
    int unsigned scaled;
    full_cnt = 32'(period_cfg) + 32'd1;
    if (pct > PCT_FULL) return '0;
    power = 32'(PCT_FULL) - 32'(pct);
    if (power == 0) return '0;
    if (power == 32'(PCT_FULL)) begin
      scaled = full_cnt;
    end else begin
      scaled = (full_cnt * power) / 32'(PCT_FULL);
      scaled = (scaled == 0) ? 0 : scaled - 1;
    end
    return (scaled > 32'hFFFF) ? 16'hFFFF : scaled[15:0];
  endfunction

  // Move a compare by one count toward its target; unchanged means reached
  function automatic cmp_t step_cmp(cmp_t cur, cmp_t tgt, bit up);
    if (up && cur < tgt) return cur + 16'd1;
    if (!up && cur > tgt) return cur - 16'd1;
    return cur;
  endfunction

  // Advance the ramp state by one request and form its result
  task automatic advance_compares(input in_req_t r, output out_rsp_t rsp, output bit acted);
    cmp_t nxt;
    cmp_t nxt_pull;
    cmp_t nxt_push;
    pct_t pull_p;
    pct_t push_p;
    rsp = '0;
    acted = 1'b0;
    case (r.func)
      FUNC_UP, FUNC_DOWN: begin
        if (r.channel <= CH_PUSH) begin
          acted = 1'b1;
          nxt = step_cmp(ramp_cmp[r.channel], compare_target(r.percent), r.func == FUNC_UP);
          rsp.reached = (nxt == ramp_cmp[r.channel]);
          ramp_cmp[r.channel] = nxt;
        end
      end
      FUNC_TICK: begin
        if (ss_running) begin
          acted = 1'b1;
          pull_p = auto_mode ? AUTO_PULL : pull_pct_cfg;
          push_p = auto_mode ? AUTO_PUSH : push_pct_cfg;
          nxt_pull = step_cmp(ramp_cmp[CH_PULL], compare_target(pull_p), 1'b0);
          nxt_push = step_cmp(ramp_cmp[CH_PUSH], compare_target(push_p), 1'b0);
          rsp.reached = (nxt_pull == ramp_cmp[CH_PULL]) && (nxt_push == ramp_cmp[CH_PUSH]);
          ramp_cmp[CH_PULL] = nxt_pull;
          ramp_cmp[CH_PUSH] = nxt_push;
          pull_pct_used = pull_p;
          push_pct_used = push_p;
          if (rsp.reached) begin
            ss_running = 1'b0;
            ss_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    rsp.pump_cmp = ramp_cmp[CH_PUMP];
    rsp.pull_cmp = ramp_cmp[CH_PULL];
    rsp.push_cmp = ramp_cmp[CH_PUSH];
    rsp.soft_done = ss_done;
    rsp.pull_pct_applied = pull_pct_used;
    rsp.push_pct_applied = push_pct_used;
  endtask

  // Offer a request, hold it until taken, then queue its result
  task automatic send_req(input in_req_t r, input bit typed, input out_rsp_t typed_rsp,
                          output bit acted);
    out_rsp_t want;
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    advance_compares(r, want, acted);
    due_rsp_q.push_back(typed ? typed_rsp : want);
  endtask

  // Drop valid and wait until the pipeline has emptied
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (due_rsp_q.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cmp_t data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_PERIOD:   period_cfg = data;
      CFG_FAN_MODE: auto_mode = data[0];
      CFG_PULL_PCT: pull_pct_cfg = data[6:0];
      CFG_PUSH_PCT: push_pct_cfg = data[6:0];
      default: ;
    endcase
  endtask

  task automatic configure(input cmp_t per, input bit mode, input pct_t pull_p,
                           input pct_t push_p);
    settle_pipeline();
    write_reg(CFG_PERIOD, per);
    write_reg(CFG_FAN_MODE, cmp_t'(mode));
    write_reg(CFG_PULL_PCT, cmp_t'(pull_p));
    write_reg(CFG_PUSH_PCT, cmp_t'(push_p));
    cfg_we <= 1'b0;
  endtask

  function automatic plan_row_t item_row(func_t f, chan_t c, pct_t p);
    plan_row_t row;
    row = '0;
    row.req = '{func: f, channel: c, percent: p};
    return row;
  endfunction

  function automatic plan_row_t checked_row(func_t f, chan_t c, pct_t p, out_rsp_t r);
    plan_row_t row;
    row = item_row(f, c, p);
    row.typed = 1'b1;
    row.rsp = r;
    return row;
  endfunction

  function automatic plan_row_t reg_row(cfg_idx_t i, cmp_t d);
    plan_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.idx = i;
    row.wdata = d;
    return row;
  endfunction

  function automatic pct_t pick_pct();
    case ($urandom_range(5))
      0: return '0;
      1: return PCT_FULL;
      2: return 7'h7F;
      default: return pct_t'($urandom_range(100));
    endcase
  endfunction

  task automatic check_field(input string name, input cmp_t want, input cmp_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Check each result against the oldest one due; drive random back-pressure
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_rsp_q.size() == 0) begin
        $display("%0t: result with none due, expected nothing, actual %h", $time, out_rsp);
        err_cnt++;
      end else begin
        want = due_rsp_q.pop_front();
        check_field("reached", cmp_t'(want.reached), cmp_t'(out_rsp.reached));
        check_field("pump_cmp", want.pump_cmp, out_rsp.pump_cmp);
        check_field("pull_cmp", want.pull_cmp, out_rsp.pull_cmp);
        check_field("push_cmp", want.push_cmp, out_rsp.push_cmp);
        check_field("soft_done", cmp_t'(want.soft_done), cmp_t'(out_rsp.soft_done));
        check_field("pull_pct_applied", cmp_t'(want.pull_pct_applied),
                    cmp_t'(out_rsp.pull_pct_applied));
        check_field("push_pct_applied", cmp_t'(want.push_pct_applied),
                    cmp_t'(out_rsp.push_pct_applied));
      end
    end
    out_stall <= !calm && ($urandom_range(99) < 10);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    bit    acted;
    int    counted;
    int    ch;
    int    np;
    int    len;
    bit    up;
    cmp_t  per;
    int    ch_pct [0:2];
    func_t f;

    ch_pct = '{0, 0, 0};

    // Reset values, saturations, ignored codes and the first soft-start ticks
    plan.push_back(checked_row(FUNC_UP, CH_PUMP, 7'd0,
                               '{1'b1, 16'd1000, 16'd1000, 16'd1000, 1'b0, 7'd0, 7'd0}));
    plan.push_back(checked_row(FUNC_DOWN, CH_PUMP, 7'd100,
                               '{1'b0, 16'd999, 16'd1000, 16'd1000, 1'b0, 7'd0, 7'd0}));
    plan.push_back(checked_row(FUNC_UP, CH_PUMP, 7'd127,
                               '{1'b1, 16'd999, 16'd1000, 16'd1000, 1'b0, 7'd0, 7'd0}));
    plan.push_back(item_row(FUNC_DOWN, CH_PULL, 7'd50));
    plan.push_back(checked_row(FUNC_UP, CH_PUSH, 7'd0,
                               '{1'b1, 16'd999, 16'd999, 16'd1000, 1'b0, 7'd0, 7'd0}));
    plan.push_back(checked_row(FUNC_UP, CH_NONE, 7'd127,
                               '{1'b0, 16'd999, 16'd999, 16'd1000, 1'b0, 7'd0, 7'd0}));
    plan.push_back(checked_row(FUNC_NONE, CH_PUMP, 7'd0,
                               '{1'b0, 16'd999, 16'd999, 16'd1000, 1'b0, 7'd0, 7'd0}));
    plan.push_back(checked_row(FUNC_TICK, CH_PUMP, 7'd0,
                               '{1'b0, 16'd999, 16'd998, 16'd999, 1'b0, 7'd60, 7'd30}));
    plan.push_back(item_row(FUNC_TICK, CH_NONE, 7'd127));
    plan.push_back(item_row(FUNC_DOWN, CH_PUSH, 7'd1));
    // Zero period: scaled value below one saturates to zero
    plan.push_back(reg_row(CFG_PERIOD, 16'd0));
    plan.push_back(item_row(FUNC_DOWN, CH_PUMP, 7'd99));
    plan.push_back(item_row(FUNC_UP, CH_PUMP, 7'd99));
    plan.push_back(item_row(FUNC_UP, CH_PULL, 7'd0));
    // Full period: full-scale target clamps to sixteen bits
    plan.push_back(reg_row(CFG_PERIOD, 16'hFFFF));
    plan.push_back(item_row(FUNC_UP, CH_PUMP, 7'd0));
    plan.push_back(item_row(FUNC_DOWN, CH_PUSH, 7'd1));
    // Manual fan targets at their extremes
    plan.push_back(reg_row(CFG_FAN_MODE, 16'd0));
    plan.push_back(reg_row(CFG_PULL_PCT, 16'd127));
    plan.push_back(reg_row(CFG_PUSH_PCT, 16'd100));
    plan.push_back(item_row(FUNC_TICK, CH_PULL, 7'd100));
    plan.push_back(item_row(FUNC_UP, CH_PUSH, 7'd100));
    plan.push_back(reg_row(CFG_PERIOD, PERIOD_RST));
    plan.push_back(reg_row(CFG_FAN_MODE, 16'd1));
    plan.push_back(reg_row(CFG_PULL_PCT, cmp_t'(PULL_PCT_RST)));
    plan.push_back(reg_row(CFG_PUSH_PCT, cmp_t'(PUSH_PCT_RST)));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle_pipeline();
        write_reg(plan[i].idx, plan[i].wdata);
        cfg_we <= 1'b0;
      end else begin
        send_req(plan[i].req, plan[i].typed, plan[i].rsp, acted);
      end
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == FinishPhase) begin
        // Fan targets at full scale: the next tick completes soft start
        configure(16'hFFFF, 1'b0, 7'd0, 7'd0);
      end else begin
        case ($urandom_range(6))
          0: per = 16'd0;
          1: per = 16'hFFFF;
          2: per = 16'd65534;
          3: per = cmp_t'($urandom_range(40, 1));
          default: per = cmp_t'($urandom_range(1500, 500));
        endcase
        configure(per, 1'($urandom_range(1)), pick_pct(), pick_pct());
      end
      calm = (ph == CalmPhase);
      if (ph == FinishPhase)
        send_req('{func: FUNC_TICK, channel: CH_PUMP, percent: 7'd0}, 1'b0, '0, acted);
      counted = 0;
      while (counted < PhaseItems) begin
        case ($urandom_range(19))
          0, 1, 2: begin
            // Soft-start ticks with junk in the unused fields
            len = $urandom_range(8, 1);
            repeat (len) begin
              send_req('{func: FUNC_TICK, channel: chan_t'($urandom_range(3)),
                         percent: pct_t'($urandom_range(127))}, 1'b0, '0, acted);
              counted += acted;
            end
          end
          3, 4: begin
            send_req(in_req_t'(11'($urandom)), 1'b0, '0, acted);
            counted += acted;
          end
          default: begin
            // Ramp a channel toward a percent near its last one
            ch = $urandom_range(2);
            if ($urandom_range(9) == 0) begin
              np = $urandom_range(127);
            end else begin
              np = ch_pct[ch] + ($urandom_range(1) ? 1 : -1) * $urandom_range(3);
              np = (np < 0) ? 0 : (np > 100) ? 100 : np;
            end
            ch_pct[ch] = (np > 100) ? 100 : np;
            up = compare_target(pct_t'(np)) > ramp_cmp[ch];
            if ($urandom_range(99) < 15) up = !up;
            f = up ? FUNC_UP : FUNC_DOWN;
            len = $urandom_range(40, 4);
            repeat (len) begin
              send_req('{func: f, channel: chan_t'(ch), percent: pct_t'(np)}, 1'b0, '0, acted);
              counted += acted;
            end
          end
        endcase
      end
    end
    calm = 1'b0;

    settle_pipeline();
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
